// ===== rtl/core/swlg_pkg.sv =====
// Shared types and constants of the sphere wireframe line generator.
`default_nettype none
package swlg_pkg;

  // Index width that covers every ring and slice count up to 256.
  localparam int IDX_W = 9;
  localparam int CRD_W = 17;
  localparam int FIFO_DEPTH = 2;

  localparam logic [1:0] REG_STACKS = 2'd0;
  localparam logic [1:0] REG_SLICES = 2'd1;
  localparam logic [1:0] REG_RADIUS = 2'd2;

  localparam logic [6:0]  STACKS_RST = 7'd8;
  localparam logic [6:0]  SLICES_RST = 7'd8;
  localparam logic [15:0] RADIUS_RST = 16'd256;

  // What the first endpoint of a line is.
  typedef enum logic [1:0] {
    SK_NORTH,
    SK_VERTEX,
    SK_SOUTH
  } start_kind_t;

  // One line as the front hands it to the back.
  typedef struct packed {
    start_kind_t            kind;
    logic [IDX_W-1:0]       sr;
    logic [IDX_W-1:0]       sj;
    logic [IDX_W-1:0]       er;
    logic [IDX_W-1:0]       ej;
    logic                   last;
  } cmd_t;

endpackage
`default_nettype wire

// ===== rtl/core/swlg_fifo.sv =====
// Two-entry queue of line commands between the front and the back.
`default_nettype none
module swlg_fifo (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              push,
  input  swlg_pkg::cmd_t   push_cmd,
  output logic             full,
  input  wire              pop,
  output swlg_pkg::cmd_t   pop_cmd,
  output logic             not_empty
);
  localparam int PW = $clog2(swlg_pkg::FIFO_DEPTH);
  localparam int CW = $clog2(swlg_pkg::FIFO_DEPTH + 1);

  swlg_pkg::cmd_t mem_r [swlg_pkg::FIFO_DEPTH];
  logic [PW-1:0] wp_r, rp_r;
  logic [CW-1:0] cnt_r;

  assign full      = (cnt_r == CW'(swlg_pkg::FIFO_DEPTH));
  assign not_empty = (cnt_r != '0);
  assign pop_cmd   = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= (wp_r == PW'(swlg_pkg::FIFO_DEPTH - 1)) ? '0 : wp_r + 1'b1;
      end
      if (pop) begin
        rp_r <= (rp_r == PW'(swlg_pkg::FIFO_DEPTH - 1)) ? '0 : rp_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end
endmodule
`default_nettype wire

// ===== rtl/core/swlg_front.sv =====
// Line sequencer: walks caps and rings and issues one command per request.
`default_nettype none
module swlg_front #(
  parameter int MAX_STACKS = 64,
  parameter int MAX_SLICES = 64
) (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire                        in_valid,
  output logic                       in_ready,
  input  wire                        in_restart,
  input  wire [swlg_pkg::IDX_W-1:0]  ns,
  input  wire [swlg_pkg::IDX_W-1:0]  nl,
  output logic                       q_push,
  output swlg_pkg::cmd_t             q_cmd,
  input  wire                        q_full
);
  localparam int RW = $clog2(MAX_STACKS);
  localparam int SW = $clog2(MAX_SLICES + 1);
  localparam int IW = swlg_pkg::IDX_W;

  typedef enum logic [1:0] {SEC_NORTH, SEC_RINGS, SEC_SOUTH} sec_t;

  sec_t          sec_r, sec_nxt, sec;
  logic [RW-1:0] ri_r, ri_nxt, ri, last_ring;
  logic [SW-1:0] si_r, si_nxt, si, si_inc;
  logic          vp_r, vp_nxt, vp;

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    sec = in_restart ? SEC_NORTH : sec_r;
    ri  = in_restart ? '0 : ri_r;
    si  = in_restart ? '0 : si_r;
    vp  = in_restart ? 1'b1 : vp_r;
    last_ring = RW'(ns - IW'(2));
    if (ri > last_ring) begin
      ri = last_ring;
    end
    if (IW'(si) >= nl) begin
      si = SW'(nl - IW'(1));
    end
    si_inc = si + 1'b1;

    sec_nxt = sec;
    ri_nxt  = ri;
    si_nxt  = si;
    vp_nxt  = vp;
    q_cmd.kind = swlg_pkg::SK_VERTEX;
    q_cmd.sr   = IW'(ri);
    q_cmd.sj   = IW'(si);
    q_cmd.er   = IW'(ri);
    q_cmd.ej   = IW'(si);
    q_cmd.last = 1'b0;

    unique case (sec)
      SEC_NORTH: begin
        q_cmd.kind = swlg_pkg::SK_NORTH;
        q_cmd.er   = '0;
        if (IW'(si_inc) >= nl) begin
          si_nxt  = '0;
          sec_nxt = SEC_RINGS;
          ri_nxt  = '0;
          vp_nxt  = 1'b1;
        end else begin
          si_nxt = si_inc;
        end
      end
      SEC_RINGS: begin
        if (vp && ri < last_ring) begin
          q_cmd.er = IW'(ri) + IW'(1);
          vp_nxt   = 1'b0;
        end else begin
          q_cmd.ej = IW'(si_inc);
          vp_nxt   = 1'b1;
          if (IW'(si_inc) >= nl) begin
            si_nxt = '0;
            if (ri == last_ring) begin
              ri_nxt  = '0;
              sec_nxt = SEC_SOUTH;
            end else begin
              ri_nxt = ri + 1'b1;
            end
          end else begin
            si_nxt = si_inc;
          end
        end
      end
      SEC_SOUTH: begin
        q_cmd.kind = swlg_pkg::SK_SOUTH;
        q_cmd.er   = IW'(last_ring);
        if (IW'(si_inc) >= nl) begin
          q_cmd.last = 1'b1;
          sec_nxt = SEC_NORTH;
          ri_nxt  = '0;
          si_nxt  = '0;
          vp_nxt  = 1'b1;
        end else begin
          si_nxt = si_inc;
        end
      end
      default: begin
        sec_nxt = SEC_NORTH;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sec_r <= SEC_NORTH;
      ri_r  <= '0;
      si_r  <= '0;
      vp_r  <= 1'b1;
    end else if (q_push) begin
      sec_r <= sec_nxt;
      ri_r  <= ri_nxt;
      si_r  <= si_nxt;
      vp_r  <= vp_nxt;
    end
  end
endmodule
`default_nettype wire

// ===== rtl/core/swlg_back.sv =====
// Vertex engine: phase divider, quarter-wave sine table and one multiplier.
`default_nettype none
module swlg_back #(
  parameter int SINE_TABLE_BITS = 10
) (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire                        q_valid,
  output logic                       q_pop,
  input  swlg_pkg::cmd_t             q_cmd,
  input  wire [swlg_pkg::IDX_W-1:0]  ns,
  input  wire [swlg_pkg::IDX_W-1:0]  nl,
  input  wire [15:0]                 radius,
  output logic                       out_valid,
  input  wire                        out_ready,
  output logic [6*swlg_pkg::CRD_W-1:0] out_data,
  output logic                       out_last
);
  localparam int STB  = SINE_TABLE_BITS;
  localparam int Q    = 1 << STB;
  localparam int PW   = STB + 2;
  localparam int IW   = swlg_pkg::IDX_W;
  localparam int NW   = IW + STB + 3;
  localparam int CNTW = $clog2(NW);
  localparam int CW   = swlg_pkg::CRD_W;

  typedef logic [15:0] sine_rom_t [0:Q];

  function automatic sine_rom_t build_sine();
    sine_rom_t         t;
    longint unsigned   x, x2, term;
    longint            sum;
    longint unsigned   v;
    for (int k = 0; k <= Q; k++) begin
      x    = (64'd3373259426 * 64'(k) + (64'd1 << STB)) >> (STB + 1);
      x2   = (x * x) >> 30;
      term = x;
      sum  = longint'(x);
      for (int n = 1; n <= 12; n++) begin
        term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
        if (n % 2 == 1) sum = sum - longint'(term);
        else            sum = sum + longint'(term);
      end
      if (sum < 0) sum = 0;
      v = (64'(sum) + 64'd16384) >> 15;
      if (v > 64'd32767) v = 64'd32767;
      t[k] = 16'(v);
    end
    return t;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine();

  // Product of Q8.8 by Q1.15, back to Q8.8, ties away from zero.
  function automatic logic signed [CW-1:0] rnd_q15(input logic signed [2*CW-2:0] p);
    logic [2*CW-2:0] m;
    logic [CW-1:0]   rv;
    m  = p[2*CW-2] ? -p : p;
    rv = CW'((m + (2*CW-1)'(16384)) >> 15);
    return p[2*CW-2] ? $signed(-rv) : $signed(rv);
  endfunction

  typedef enum logic [2:0] {B_IDLE, B_DIVP, B_DIVT, B_TAB, B_MUL, B_OUT} bstate_t;

  bstate_t                state_r;
  swlg_pkg::cmd_t         cmd_r;
  logic                   vsel_r;
  logic [CNTW-1:0]        cnt_r;
  logic [NW-1:0]          num_r;
  logic [IW:0]            rem_r;
  logic [IW-1:0]          vj_r;
  logic [PW-1:0]          phi_r, th_r;
  logic [15:0]            tab_q_r;
  logic                   neg_r;
  logic signed [15:0]     sv_r [4];
  logic signed [2*CW-2:0] prod_r;
  logic signed [CW-1:0]   a_r;
  logic signed [CW-1:0]   crd_r [6];
  logic                   out_valid_r, out_last_r;
  logic [6*CW-1:0]        out_data_r;

  logic [IW-1:0]   nr, nj;
  logic [NW-1:0]   phi_num, th_num;
  logic [IW:0]     rem_sh, divisor;
  logic            qbit;
  logic [NW-1:0]   num_step;
  logic [PW-1:0]   tphase;
  logic [STB:0]    taddr;
  logic signed [CW-1:0] mul_a;
  logic [1:0]      dk;

  always_comb begin
    if (state_r == B_IDLE) begin
      nr = (q_cmd.kind == swlg_pkg::SK_VERTEX) ? q_cmd.sr : q_cmd.er;
      nj = (q_cmd.kind == swlg_pkg::SK_VERTEX) ? q_cmd.sj : q_cmd.ej;
    end else begin
      nr = cmd_r.er;
      nj = cmd_r.ej;
    end
    phi_num = (NW'(nr) + NW'(1)) << (STB + 1);
    phi_num = phi_num + NW'(ns >> 1);
    th_num  = (NW'(vj_r) << (STB + 2)) + NW'(nl >> 1);

    divisor  = (state_r == B_DIVT) ? {1'b0, nl} : {1'b0, ns};
    rem_sh   = {rem_r[IW-1:0], num_r[NW-1]};
    qbit     = (rem_sh >= divisor);
    num_step = {num_r[NW-2:0], qbit};

    unique case (cnt_r[1:0])
      2'd0:    tphase = phi_r;
      2'd1:    tphase = phi_r + PW'(Q);
      2'd2:    tphase = th_r + PW'(Q);
      default: tphase = th_r;
    endcase
    taddr = tphase[PW-2] ? (STB+1)'(Q) - (STB+1)'(tphase[STB-1:0])
                         : (STB+1)'(tphase[STB-1:0]);

    mul_a = (cnt_r < CNTW'(2)) ? $signed({1'b0, radius}) : a_r;
    dk    = 2'(cnt_r - CNTW'(1));
  end

  assign q_pop     = (state_r == B_IDLE) && q_valid;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_last  = out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
      vsel_r      <= 1'b0;
    end else begin
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        B_IDLE: begin
          if (q_valid) begin
            cmd_r <= q_cmd;
            vj_r  <= nj;
            num_r <= phi_num;
            rem_r <= '0;
            cnt_r <= '0;
            vsel_r <= (q_cmd.kind != swlg_pkg::SK_VERTEX);
            if (q_cmd.kind != swlg_pkg::SK_VERTEX) begin
              crd_r[0] <= '0;
              crd_r[2] <= '0;
              crd_r[1] <= (q_cmd.kind == swlg_pkg::SK_NORTH) ? $signed({1'b0, radius})
                                                             : -$signed({1'b0, radius});
            end
            state_r <= B_DIVP;
          end
        end
        B_DIVP, B_DIVT: begin
          rem_r <= qbit ? rem_sh - divisor : rem_sh;
          num_r <= num_step;
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == CNTW'(NW - 1)) begin
            cnt_r <= '0;
            rem_r <= '0;
            if (state_r == B_DIVP) begin
              phi_r   <= num_step[PW-1:0];
              num_r   <= th_num;
              state_r <= B_DIVT;
            end else begin
              th_r    <= num_step[PW-1:0];
              state_r <= B_TAB;
            end
          end
        end
        B_TAB: begin
          tab_q_r <= SINE_ROM[taddr];
          neg_r   <= tphase[PW-1];
          if (cnt_r != '0) begin
            sv_r[dk] <= neg_r ? -$signed(tab_q_r) : $signed(tab_q_r);
          end
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == CNTW'(4)) begin
            cnt_r   <= '0;
            state_r <= B_MUL;
          end
        end
        B_MUL: begin
          prod_r <= mul_a * sv_r[cnt_r[1:0]];
          if (cnt_r != '0) begin
            unique case (dk)
              2'd0:    a_r <= rnd_q15(prod_r);
              2'd1:    crd_r[vsel_r ? 4 : 1] <= rnd_q15(prod_r);
              2'd2:    crd_r[vsel_r ? 3 : 0] <= rnd_q15(prod_r);
              default: crd_r[vsel_r ? 5 : 2] <= rnd_q15(prod_r);
            endcase
          end
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == CNTW'(4)) begin
            cnt_r <= '0;
            if (!vsel_r) begin
              vsel_r  <= 1'b1;
              vj_r    <= nj;
              num_r   <= phi_num;
              rem_r   <= '0;
              state_r <= B_DIVP;
            end else begin
              state_r <= B_OUT;
            end
          end
        end
        B_OUT: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            out_last_r  <= cmd_r.last;
            out_data_r  <= {crd_r[5], crd_r[4], crd_r[3], crd_r[2], crd_r[1], crd_r[0]};
            state_r     <= B_IDLE;
          end
        end
        default: begin
          state_r <= B_IDLE;
        end
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== rtl/core/sphere_wireframe_line_generator.sv =====
// A cap spoke computes one vertex from request to result, a ring line computes two.
// Each vertex costs two bit-serial phase divisions of IDX_W+SINE_TABLE_BITS+3 quotient bits each
// (22 at the defaults), four sine table reads and four multiplies on one shared multiplier.
// The back works on one line at a time; the command queue lets requests be taken meanwhile.
// Reset (synchronous, active low) returns the sequence to the first north-cap spoke,
// loads the default registers and empties the queue and the output register.
`default_nettype none
module sphere_wireframe_line_generator #(
  parameter int MAX_STACKS      = 64,
  parameter int MAX_SLICES      = 64,
  parameter int SINE_TABLE_BITS = 10
) (
  input  wire          clk,
  input  wire          rst_n,
  input  wire          in_tvalid,
  output logic         in_tready,
  input  wire  [7:0]   in_tdata,   // [0] restart, [7:1] zero
  output logic         out_tvalid,
  input  wire          out_tready,
  output logic [103:0] out_tdata,  // start_x, start_y, start_z, end_x, end_y, end_z (17 each), zero
  output logic         out_tlast,  // last_line
  input  wire          cfg_we,
  input  wire  [1:0]   cfg_addr,
  input  wire  [15:0]  cfg_wdata
);
  localparam int IW = swlg_pkg::IDX_W;

  // Configuration registers; the user must write them only while the block is idle, the block does not enforce it.
  logic [6:0]  stacks_r, slices_r;
  logic [15:0] radius_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stacks_r <= swlg_pkg::STACKS_RST;
      slices_r <= swlg_pkg::SLICES_RST;
      radius_r <= swlg_pkg::RADIUS_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        swlg_pkg::REG_STACKS: stacks_r <= cfg_wdata[6:0];
        swlg_pkg::REG_SLICES: slices_r <= cfg_wdata[6:0];
        swlg_pkg::REG_RADIUS: radius_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Counts are clamped into the range the hardware supports before use.
  logic [IW-1:0] ns, nl;

  always_comb begin
    if (IW'(stacks_r) < IW'(2)) begin
      ns = IW'(2);
    end else if (IW'(stacks_r) > IW'(MAX_STACKS)) begin
      ns = IW'(MAX_STACKS);
    end else begin
      ns = IW'(stacks_r);
    end
    if (IW'(slices_r) < IW'(1)) begin
      nl = IW'(1);
    end else if (IW'(slices_r) > IW'(MAX_SLICES)) begin
      nl = IW'(MAX_SLICES);
    end else begin
      nl = IW'(slices_r);
    end
  end

  logic           q_push, q_full, q_pop, q_valid;
  swlg_pkg::cmd_t push_cmd, pop_cmd;
  logic [101:0]   coords;

  // The front decides which two vertices make the next line.
  swlg_front #(
    .MAX_STACKS (MAX_STACKS),
    .MAX_SLICES (MAX_SLICES)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_restart (in_tdata[0]),
    .ns         (ns),
    .nl         (nl),
    .q_push     (q_push),
    .q_cmd      (push_cmd),
    .q_full     (q_full)
  );

  swlg_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_cmd  (push_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .pop_cmd   (pop_cmd),
    .not_empty (q_valid)
  );

  // The back computes the endpoint coordinates and holds the result register.
  swlg_back #(
    .SINE_TABLE_BITS (SINE_TABLE_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_cmd     (pop_cmd),
    .ns        (ns),
    .nl        (nl),
    .radius    (radius_r),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (coords),
    .out_last  (out_tlast)
  );

  assign out_tdata = {2'b00, coords};
endmodule
`default_nettype wire

// ===== rtl/core/swlg_checker.sv =====
// Port-level checks of the sphere wireframe line generator and their binding.
`default_nettype none
module swlg_checker (
  input wire         clk,
  input wire         rst_n,
  input wire         out_tvalid,
  input wire         out_tready,
  input wire [103:0] out_tdata,
  input wire         out_tlast
);
  // A stalled result stays offered.
  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid) else $error("result withdrawn");

  // A stalled result keeps its value.
  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled result changed");

  // Reset empties the output register.
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result offered after reset");

  // The last line is a south-cap spoke, so it starts on the axis.
  a_last_pole: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tdata[16:0] == 17'd0 && out_tdata[50:34] == 17'd0)
    else $error("last line does not start at the pole");
endmodule

bind sphere_wireframe_line_generator swlg_checker u_swlg_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
`default_nettype wire

// ===== test/sphere_wireframe_line_generator_tb.sv =====
// Self-checking testbench for the sphere wireframe line generator.
`timescale 1ns / 1ps
`default_nettype none
module sphere_wireframe_line_generator_tb;

  // The table and phase arithmetic below follow the block's default parameters.
  localparam int TABLE_BITS = 10;
  localparam int QTR        = 1 << TABLE_BITS;
  localparam int STACKS_MAX = 64;
  localparam int SLICES_MAX = 64;
  // Long enough for one ring line in flight and a spare.
  localparam int SETTLE     = 250;
  // Longest stretch without any request or result moving before the run is abandoned.
  localparam int STALL_LIMIT = 6000;
  localparam int HOLD_LEN    = 600;

  typedef struct packed {
    logic [swlg_pkg::CRD_W-1:0] sx, sy, sz, ex, ey, ez;
    logic                       last;
  } line_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [7:0]   in_tdata = '0;    // [0] restart, [7:1] zero
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [103:0] out_tdata;        // start_x, start_y, start_z, end_x, end_y, end_z, zero
  logic         out_tlast;        // last_line
  logic         cfg_we = 1'b0;
  logic [1:0]   cfg_addr = swlg_pkg::REG_STACKS;
  logic [15:0]  cfg_wdata = '0;

  sphere_wireframe_line_generator dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Percentages of cycles in which each side holds back; changed between phases.
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_left = 0;
  int errors = 0;
  int lines_sent = 0;
  int lines_seen = 0;
  int frames_seen = 0;
  int stall_count = 0;

  // Expected lines, oldest first.
  line_t lines_due[$];

  // Predictor copy of the registers and of the sequence position.
  logic [6:0]  p_stacks = swlg_pkg::STACKS_RST;
  logic [6:0]  p_slices = swlg_pkg::SLICES_RST;
  logic [15:0] p_radius = swlg_pkg::RADIUS_RST;
  logic [1:0]  p_section = 2'd0;
  int unsigned p_ring = 0;
  int unsigned p_slice = 0;
  bit          p_vert = 1'b1;

  longint sine_q15 [0:QTR];

  // Quarter-wave sine table: a Taylor series on a 30-fraction-bit angle, rounded to Q1.15.
  function automatic void fill_sine_table();
    longint unsigned x, x2, term, den;
    longint sum;
    longint v;
    for (int k = 0; k <= QTR; k++) begin
      x = (64'd3373259426 * k + (64'd1 << TABLE_BITS)) >> (TABLE_BITS + 1);
      x2 = (x * x) >> 30;
      term = x;
      sum = longint'(x);
      for (int n = 1; n <= 12; n++) begin
        den = (2 * n) * (2 * n + 1);
        term = ((term * x2) >> 30) / den;
        if (n % 2 == 1) sum -= longint'(term);
        else sum += longint'(term);
      end
      if (sum < 0) sum = 0;
      v = (sum + (64'd1 << 14)) >>> 15;
      if (v > 32767) v = 32767;
      sine_q15[k] = v;
    end
  endfunction

  function automatic longint sine_of_phase(int unsigned ph);
    int unsigned quad, idx;
    longint v;
    ph = ph & (4 * QTR - 1);
    quad = ph >> TABLE_BITS;
    idx = ph & (QTR - 1);
    v = quad[0] ? sine_q15[QTR - idx] : sine_q15[idx];
    return quad[1] ? -v : v;
  endfunction

  // Q8.8 by Q1.15, rounded to nearest with ties away from zero.
  function automatic longint scale_q15(longint a, longint s);
    longint p, m, r;
    p = a * s;
    m = (p < 0) ? -p : p;
    r = (m + 16384) >>> 15;
    return (p < 0) ? -r : r;
  endfunction

  function automatic void sphere_point(int unsigned r, int unsigned j, int unsigned ns,
                                       int unsigned nl,
                                       output logic [swlg_pkg::CRD_W-1:0] vx,
                                       output logic [swlg_pkg::CRD_W-1:0] vy,
                                       output logic [swlg_pkg::CRD_W-1:0] vz);
    int unsigned phi, th;
    longint a;
    phi = ((r + 1) * 2 * QTR + ns / 2) / ns;
    th = (j * 4 * QTR + nl / 2) / nl;
    a = scale_q15(longint'(p_radius), sine_of_phase(phi));
    vx = swlg_pkg::CRD_W'(scale_q15(a, sine_of_phase(th + QTR)));
    vy = swlg_pkg::CRD_W'(scale_q15(longint'(p_radius), sine_of_phase(phi + QTR)));
    vz = swlg_pkg::CRD_W'(scale_q15(a, sine_of_phase(th)));
  endfunction

  function automatic void rewind_sequence();
    p_section = 2'd0;
    p_ring = 0;
    p_slice = 0;
    p_vert = 1'b1;
  endfunction

  // Works out the next line of the wireframe and advances the sequence position.
  function automatic line_t next_line(bit restart);
    line_t ln;
    int unsigned ns, nl, last_ring;
    ln = '0;
    ns = p_stacks;
    nl = p_slices;
    // Out-of-range register values are clamped on every line.
    if (ns < 2) ns = 2;
    if (ns > STACKS_MAX) ns = STACKS_MAX;
    if (nl < 1) nl = 1;
    if (nl > SLICES_MAX) nl = SLICES_MAX;
    last_ring = ns - 2;
    if (restart || p_section > 2'd2) rewind_sequence();
    // A register change partway through a frame pulls the position back inside the mesh.
    if (p_ring > last_ring) p_ring = last_ring;
    if (p_slice >= nl) p_slice = nl - 1;
    case (p_section)
      2'd0: begin
        ln.sy = swlg_pkg::CRD_W'(p_radius);
        sphere_point(0, p_slice, ns, nl, ln.ex, ln.ey, ln.ez);
        p_slice++;
        if (p_slice >= nl) begin
          p_slice = 0;
          p_section = 2'd1;
          p_ring = 0;
          p_vert = 1'b1;
        end
      end
      2'd1: begin
        sphere_point(p_ring, p_slice, ns, nl, ln.sx, ln.sy, ln.sz);
        if (p_vert && p_ring < last_ring) begin
          sphere_point(p_ring + 1, p_slice, ns, nl, ln.ex, ln.ey, ln.ez);
          p_vert = 1'b0;
        end else begin
          // The seam: slice index nl lands on the same phase as slice 0.
          sphere_point(p_ring, p_slice + 1, ns, nl, ln.ex, ln.ey, ln.ez);
          p_vert = 1'b1;
          p_slice++;
          if (p_slice >= nl) begin
            p_slice = 0;
            p_ring++;
            if (p_ring > last_ring) begin
              p_ring = 0;
              p_section = 2'd2;
            end
          end
        end
      end
      default: begin
        ln.sy = swlg_pkg::CRD_W'(-longint'(p_radius));
        sphere_point(last_ring, p_slice, ns, nl, ln.ex, ln.ey, ln.ez);
        if (p_slice + 1 >= nl) begin
          ln.last = 1'b1;
          rewind_sequence();
        end else begin
          p_slice++;
        end
      end
    endcase
    return ln;
  endfunction

  task automatic report_mismatch(string what, logic [swlg_pkg::CRD_W-1:0] got,
                                 logic [swlg_pkg::CRD_W-1:0] want);
    errors++;
    $display("mismatch on line %0d, %s: got %0d, expected %0d", lines_seen, what,
             $signed(got), $signed(want));
  endtask

  // Every accepted request yields exactly one expected line.
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      lines_due.push_back(next_line(in_tdata[0]));
      lines_sent++;
    end
  end

  always @(posedge clk) begin
    line_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (lines_due.size() == 0) begin
        errors++;
        $display("line %0d arrived with nothing outstanding", lines_seen);
      end else begin
        want = lines_due.pop_front();
        if (out_tdata[16:0]  !== want.sx) report_mismatch("start_x", out_tdata[16:0], want.sx);
        if (out_tdata[33:17] !== want.sy) report_mismatch("start_y", out_tdata[33:17], want.sy);
        if (out_tdata[50:34] !== want.sz) report_mismatch("start_z", out_tdata[50:34], want.sz);
        if (out_tdata[67:51] !== want.ex) report_mismatch("end_x", out_tdata[67:51], want.ex);
        if (out_tdata[84:68] !== want.ey) report_mismatch("end_y", out_tdata[84:68], want.ey);
        if (out_tdata[101:85] !== want.ez) report_mismatch("end_z", out_tdata[101:85], want.ez);
        if (out_tlast !== want.last) report_mismatch("last_line", out_tlast, want.last);
        if (want.last) frames_seen++;
      end
      lines_seen++;
    end
  end

  // Receiver: random back-pressure, plus a long hold-off when one is requested.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog on cycles in which nothing moves on either channel.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n) begin
      stall_count <= 0;
    end else if (stall_count >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      stall_count <= stall_count + 1;
    end
  end

  // Offers one request, idling first at the current rate; called and left at a falling edge.
  task automatic send_request(bit restart);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {7'd0, restart};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_run(int count, int restart_pct);
    for (int i = 0; i < count; i++) send_request($urandom_range(99) < restart_pct);
  endtask

  // Waits for every outstanding line and for the block to settle, then writes a register.
  task automatic write_reg(logic [1:0] addr, logic [15:0] value);
    in_tvalid <= 1'b0;
    while (lines_due.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= addr;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (addr)
      swlg_pkg::REG_STACKS: p_stacks = value[6:0];
      swlg_pkg::REG_SLICES: p_slices = value[6:0];
      default:              p_radius = value;
    endcase
  endtask

  task automatic set_shape(logic [15:0] stacks_v, logic [15:0] slices_v, logic [15:0] radius_v);
    write_reg(swlg_pkg::REG_STACKS, stacks_v);
    write_reg(swlg_pkg::REG_SLICES, slices_v);
    write_reg(swlg_pkg::REG_RADIUS, radius_v);
  endtask

  // Default registers straight after reset, including a restart in the north cap.
  task automatic test_reset_defaults();
    send_run(6, 0);
    send_request(1'b1);
    send_run(3, 0);
  endtask

  // Smallest mesh wraps after three lines; largest mesh, zero and full radius, clamped registers.
  task automatic test_extremes();
    set_shape(16'd2, 16'd1, 16'hFFFF);
    send_request(1'b1);
    send_run(6, 0);
    set_shape(16'd64, 16'd64, 16'd0);
    send_request(1'b1);
    send_run(3, 0);
    set_shape(16'd127, 16'd0, 16'h8001);
    send_request(1'b1);
    send_run(3, 0);
    write_reg(swlg_pkg::REG_STACKS, 16'd1);
    send_run(3, 0);
  endtask

  function automatic logic [15:0] pick_stacks();
    int roll = $urandom_range(99);
    if (roll < 70) return 16'($urandom_range(6, 2));
    if (roll < 80) return 16'($urandom_range(1, 0));
    if (roll < 90) return 16'($urandom_range(127, 65));
    return 16'($urandom_range(64, 7));
  endfunction

  function automatic logic [15:0] pick_slices();
    int roll = $urandom_range(99);
    if (roll < 70) return 16'($urandom_range(6, 1));
    if (roll < 80) return 16'd0;
    if (roll < 90) return 16'($urandom_range(127, 65));
    return 16'($urandom_range(64, 7));
  endfunction

  // Random meshes; frames are left unfinished across register changes on purpose.
  task automatic test_random_meshes(int phases, int per_phase);
    logic [15:0] radius_v;
    for (int p = 0; p < phases; p++) begin
      case ($urandom_range(3))
        0: radius_v = 16'hFFFF;
        1: radius_v = 16'($urandom_range(512));
        default: radius_v = 16'($urandom);
      endcase
      set_shape(pick_stacks(), pick_slices(), radius_v);
      send_run(per_phase, 3);
    end
  endtask

  // The receiver stops for a long stretch while requests keep coming, so the queue fills.
  task automatic test_back_pressure();
    set_shape(16'd4, 16'd3, 16'd300);
    @(posedge clk);
    hold_left = HOLD_LEN;
    @(negedge clk);
    send_run(12, 0);
  endtask

  initial begin
    fill_sine_table();
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_reset_defaults();
    test_extremes();

    send_idle_pct = 17;
    recv_idle_pct = 78;
    test_random_meshes(5, 60);
    send_idle_pct = 78;
    recv_idle_pct = 17;
    test_random_meshes(5, 60);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_meshes(5, 60);
    test_back_pressure();

    in_tvalid <= 1'b0;
    while (lines_due.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);

    $display("Covered %0d requests and %0d lines, %0d complete frames, across default,",
             lines_sent, lines_seen, frames_seen);
    $display("extreme, clamped and random mesh shapes under varied back-pressure.");
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire
